// File: rtl/core/bmtm_pkg.sv
// Shared types and constants of the two-state transition matrix unit.
`default_nettype none
package bmtm_pkg;

	// request codes
	localparam logic [1:0] MODE_PROB = 2'd0;
	localparam logic [1:0] MODE_D1   = 2'd1;
	localparam logic [1:0] MODE_D2   = 2'd2;

	// configuration register indexes
	localparam logic REG_KAPPA = 1'b0;
	localparam logic REG_RATE  = 1'b1;

	localparam logic [32:0] Q32       = 33'h1_0000_0000;
	localparam logic [46:0] MAG_MAX   = 47'h7FFF_FFFF_FFFF;
	localparam logic [31:0] LN2_Q32   = 32'd2977044472;
	localparam logic [32:0] LOG2E_Q32 = 33'd6196328019;
	localparam int          EXP_TERMS = 12;

	// request sideband that travels with each item
	typedef struct packed {
		logic [1:0] mode;
		logic       row;
		logic       col;
	} side_t;

	// constants derived from kappa and rate
	typedef struct packed {
		logic [23:0] rate;
		logic [31:0] inv;
		logic [31:0] half;
		logic [39:0] hko;
		logic [63:0] dr;
		logic [47:0] ca;
		logic [55:0] cb;
		logic [47:0] rr;
	} cfg_t;

endpackage
`default_nettype wire

// File: rtl/core/bmtm_setup.sv
// Configuration registers and sequencer that derives the kappa and rate constants.
`default_nettype none
module bmtm_setup import bmtm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [23:0] cfg_data,
	output logic        busy,
	output cfg_t        cfg
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_LOAD = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_MUL  = 4'b1000
	} st_t;

	localparam logic [2:0] OP_INV   = 3'd0;
	localparam logic [2:0] OP_HKO   = 3'd1;
	localparam logic [2:0] OP_DECAY = 3'd2;
	localparam logic [2:0] OP_DR    = 3'd3;
	localparam logic [2:0] OP_CA    = 3'd4;
	localparam logic [2:0] OP_CB    = 3'd5;
	localparam logic [2:0] OP_RR    = 3'd6;

	localparam logic [6:0] DIV_LAST = 7'd64;
	localparam logic [6:0] MUL_LAST = 7'd4;

	st_t         st_q;
	logic [2:0]  op_q;
	logic [6:0]  cnt_q;
	logic [23:0] kappa_q, rate_q;
	logic [31:0] inv_q, half_q;
	logic [39:0] hko_q, decay_q;
	logic [63:0] dr_q;
	logic [47:0] ca_q, rr_q;
	logic [55:0] cb_q;

	// shared datapath
	logic [64:0] dvd_q, quo_q;
	logic [24:0] dvs_q, rem_q;
	logic [79:0] acc_q;
	logic [39:0] ma_q, mb_q;

	logic [24:0] k1;
	logic [49:0] sq;
	logic [25:0] rem_sh;
	logic        ge;
	logic [24:0] rem_nx;
	logic [64:0] quo_nx;
	logic [79:0] acc_nx;
	logic        kz;

	assign k1     = kappa_q + 25'd65536;
	assign sq     = 50'(k1) * 50'(k1);
	assign kz     = (kappa_q == 24'd0);
	assign rem_sh = {rem_q, dvd_q[64]};
	assign ge     = (rem_sh >= {1'b0, dvs_q});
	assign rem_nx = ge ? 25'(rem_sh - {1'b0, dvs_q}) : rem_sh[24:0];
	assign quo_nx = {quo_q[63:0], ge};
	assign acc_nx = {acc_q[71:0], 8'b0} + 80'(48'(ma_q) * 48'(mb_q[39:32]));

	assign busy = (st_q != ST_IDLE) | cfg_we;
	assign cfg  = '{rate: rate_q, inv: inv_q, half: half_q, hko: hko_q,
	                dr: dr_q, ca: ca_q, cb: cb_q, rr: rr_q};

	// sequencer and derived constants
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			op_q    <= OP_INV;
			cnt_q   <= '0;
			kappa_q <= 24'd65536;
			rate_q  <= 24'd65536;
			inv_q   <= 32'h8000_0000;
			half_q  <= 32'h0100_0000;
			hko_q   <= 40'h00_0100_0000;
			decay_q <= 40'h02_0000_0000;
			dr_q    <= 64'h0002_0000_0000_0000;
			ca_q    <= 48'h0002_0000_0000;
			cb_q    <= 56'h00_0002_0000_0000;
			rr_q    <= 48'h0001_0000_0000;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KAPPA: kappa_q <= cfg_data;
				REG_RATE:  rate_q  <= cfg_data;
				default:   rate_q  <= rate_q;
			endcase
			st_q <= ST_LOAD;
			op_q <= OP_INV;
		end else begin
			case (st_q)
				ST_LOAD: begin
					cnt_q <= '0;
					st_q  <= (op_q <= OP_DECAY) ? ST_DIV : ST_MUL;
				end
				ST_DIV: begin
					if (cnt_q == DIV_LAST) begin
						case (op_q)
							OP_INV: begin
								inv_q  <= kz ? 32'hFFFF_FFFF : quo_nx[31:0];
								half_q <= {k1, 7'b0};
							end
							OP_HKO:  hko_q <= kz ? '1 : quo_nx[39:0];
							default: decay_q <= (kz | (|quo_nx[64:40])) ? '1 : quo_nx[39:0];
						endcase
						op_q <= op_q + 3'd1;
						st_q <= ST_LOAD;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				ST_MUL: begin
					if (cnt_q == MUL_LAST) begin
						case (op_q)
							OP_DR:   dr_q <= acc_nx[63:0];
							OP_CA:   ca_q <= acc_nx[71:24];
							OP_CB:   cb_q <= acc_nx[79:24];
							default: rr_q <= acc_nx[47:0];
						endcase
						op_q <= op_q + 3'd1;
						st_q <= (op_q == OP_RR) ? ST_IDLE : ST_LOAD;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// restoring divider, one quotient bit a cycle; byte-serial multiplier
	always_ff @(posedge clk) begin
		case (st_q)
			ST_LOAD: begin
				rem_q <= '0;
				acc_q <= '0;
				case (op_q)
					OP_INV: begin
						dvd_q <= 65'(1) << 48;
						dvs_q <= k1;
					end
					OP_HKO: begin
						dvd_q <= 65'(k1) << 23;
						dvs_q <= {1'b0, kappa_q};
					end
					OP_DECAY: begin
						dvd_q <= 65'(sq) << 15;
						dvs_q <= {1'b0, kappa_q};
					end
					OP_DR: begin
						ma_q <= decay_q;
						mb_q <= 40'(rate_q);
					end
					OP_CA: begin
						ma_q <= decay_q;
						mb_q <= 40'(half_q);
					end
					OP_CB: begin
						ma_q <= decay_q;
						mb_q <= hko_q;
					end
					default: begin
						ma_q <= 40'(rate_q);
						mb_q <= 40'(rate_q);
					end
				endcase
			end
			ST_DIV: begin
				dvd_q <= {dvd_q[63:0], 1'b0};
				rem_q <= rem_nx;
				quo_q <= quo_nx;
			end
			ST_MUL: begin
				acc_q <= acc_nx;
				mb_q  <= {mb_q[31:0], 8'b0};
			end
			default: acc_q <= acc_q;
		endcase
	end

endmodule
`default_nettype wire

// File: rtl/core/bmtm_exp.sv
// Pipelined decay factor e = exp(-lambda*rate*d): range reduction, table, polynomial.
`default_nettype none
module bmtm_exp import bmtm_pkg::*; #(
	parameter int EXP_TABLE_BITS = 8
) (
	input  logic        clk,
	input  logic [6:0]  en,
	input  logic [63:0] dr,
	input  logic [31:0] branch_length,
	input  side_t       side_in,
	output logic [32:0] e_out,
	output side_t       side_out
);

	localparam int B        = EXP_TABLE_BITS;
	localparam int RW       = 32 - B;
	localparam int TAB_SIZE = 1 << B;

	// 2^-(k/2^B) in Q1.32 by a truncated Horner series, at elaboration
	function automatic logic [32:0] exp_entry(input int unsigned k);
		logic [63:0] u, acc, prod;
		u   = (64'(k) * 64'(LN2_Q32)) >> B;
		acc = 64'(Q32);
		for (int n = EXP_TERMS; n >= 1; n--) begin
			prod = u * acc;
			acc  = 64'(Q32) - ((prod >> 32) / 64'(n));
		end
		return acc[32:0];
	endfunction

	logic [32:0] tab [TAB_SIZE];

	for (genvar k = 0; k < TAB_SIZE; k++) begin : g_tab
		localparam logic [32:0] ENTRY = exp_entry(k);
		assign tab[k] = ENTRY;
	end

	logic [63:0]     phi_s1, plo_s1;
	logic [36:0]     x_s2;
	logic            big_s2, big_s3;
	logic [37:0]     yh_s3;
	logic [64:0]     yl_s3;
	logic [RW-1:0]   r_s4, r_s5;
	logic [B-1:0]    idx_s4;
	logic [5:0]      n_s4, n_s5, n_s6;
	logic            zero_s4, zero_s5, zero_s6;
	logic [2*RW-1:0] sq_s5;
	logic [32:0]     t_s5, t_s6;
	logic [RW+32:0]  tq_s6;
	logic [32:0]     e_s7;
	side_t           side_s1, side_s2, side_s3, side_s4, side_s5, side_s6, side_s7;

	logic [95:0]    psum;
	logic [37:0]    y;
	logic [RW+31:0] rp;
	logic [RW-1:0]  q;
	logic [32:0]    m;

	assign psum = {phi_s1, 32'b0} + 96'(plo_s1);
	assign y    = yh_s3 + 38'(yl_s3[64:32]);
	assign rp   = (RW+32)'(y[RW-1:0]) * (RW+32)'(LN2_Q32);
	assign q    = r_s5 - RW'(sq_s5 >> 33);
	assign m    = t_s6 - 33'(tq_s6 >> 32);

	always_ff @(posedge clk) begin
		// s1: exponent product, split into two 32-bit halves of lambda*rate
		if (en[0]) begin
			phi_s1  <= 64'(dr[63:32]) * 64'(branch_length);
			plo_s1  <= 64'(dr[31:0]) * 64'(branch_length);
			side_s1 <= side_in;
		end
		// s2: combine, x = lambda*rate*d in Q5.32
		if (en[1]) begin
			x_s2    <= psum[76:40];
			big_s2  <= |psum[95:77];
			side_s2 <= side_s1;
		end
		// s3: scale to base 2
		if (en[2]) begin
			yh_s3   <= 38'(x_s2[36:32]) * 38'(LOG2E_Q32);
			yl_s3   <= 65'(x_s2[31:0]) * 65'(LOG2E_Q32);
			big_s3  <= big_s2;
			side_s3 <= side_s2;
		end
		// s4: integer part, table index, remainder back in natural units
		if (en[3]) begin
			r_s4    <= rp[RW+31:32];
			idx_s4  <= y[31:RW];
			n_s4    <= y[37:32];
			zero_s4 <= big_s3 | (y[37:32] > 6'd32);
			side_s4 <= side_s3;
		end
		// s5: table read and square of remainder
		if (en[4]) begin
			r_s5    <= r_s4;
			sq_s5   <= (2*RW)'(r_s4) * (2*RW)'(r_s4);
			t_s5    <= tab[idx_s4];
			n_s5    <= n_s4;
			zero_s5 <= zero_s4;
			side_s5 <= side_s4;
		end
		// s6: 1-exp(-r) by polynomial, times table entry
		if (en[5]) begin
			tq_s6   <= (RW+33)'(t_s5) * (RW+33)'(q);
			t_s6    <= t_s5;
			n_s6    <= n_s5;
			zero_s6 <= zero_s5;
			side_s6 <= side_s5;
		end
		// s7: apply the power of two
		if (en[6]) begin
			e_s7    <= zero_s6 ? '0 : (m >> n_s6);
			side_s7 <= side_s6;
		end
	end

	assign e_out    = e_s7;
	assign side_out = side_s7;

endmodule
`default_nettype wire

// File: rtl/core/bmtm_mat.sv
// Pipelined matrix entries from the decay factor, with saturation and entry select.
`default_nettype none
module bmtm_mat import bmtm_pkg::*; (
	input  logic        clk,
	input  logic [5:0]  en,
	input  cfg_t        cfg,
	input  logic [32:0] e_in,
	input  side_t       side_in,
	output logic [47:0] entry_00,
	output logic [47:0] entry_01,
	output logic [47:0] entry_10,
	output logic [47:0] entry_11,
	output logic [47:0] selected_entry,
	output logic        overflow
);

	logic [47:0] ph_s8;
	logic [63:0] pl_s8;
	logic        eh_s8;
	logic [32:0] om_s8;
	logic [48:0] g_s9;
	logic [63:0] ll_s10 [2];
	logic [48:0] lh_s10 [2];
	logic [55:0] hl_s10 [2];
	logic [40:0] hh_s10 [2];
	logic [63:0] ll_s11 [2];
	logic [56:0] mid_s11 [2];
	logic [40:0] hh_s11 [2];
	logic [46:0] mag_s12 [2];
	logic        sat_s12 [2];
	logic [47:0] v_s13 [4];
	logic [47:0] sel_s13;
	logic        ov_s13;
	side_t       side_s8, side_s9, side_s10, side_s11, side_s12;

	logic [47:0]  r_in, r_s8;
	logic [79:0]  tot;
	logic [48:0]  g;
	logic [55:0]  coef [2];
	logic [104:0] prod [2];
	logic [80:0]  val [2];
	logic [47:0]  a48, b48;
	logic [47:0]  v [4];

	assign r_in = (side_in.mode == MODE_D2) ? cfg.rr : 48'(cfg.rate);
	assign r_s8 = (side_s8.mode == MODE_D2) ? cfg.rr : 48'(cfg.rate);
	assign tot  = {ph_s8, 32'b0} + 80'(pl_s8) + (eh_s8 ? {r_s8, 32'b0} : 80'd0);

	// common factor of each request
	always_comb begin
		case (side_s8.mode)
			MODE_PROB: g = 49'(om_s8);
			MODE_D1:   g = tot[64:16];
			MODE_D2:   g = 49'(tot[79:32]);
			default:   g = '0;
		endcase
	end

	// two coefficients per request
	always_comb begin
		case (side_s9.mode)
			MODE_PROB: begin
				coef[0] = 56'(cfg.inv);
				coef[1] = 56'(Q32 - 33'(cfg.inv));
			end
			MODE_D1: begin
				coef[0] = 56'(cfg.half);
				coef[1] = 56'(cfg.hko);
			end
			MODE_D2: begin
				coef[0] = 56'(cfg.ca);
				coef[1] = cfg.cb;
			end
			default: begin
				coef[0] = '0;
				coef[1] = '0;
			end
		endcase
	end

	// scale; first derivative is Q24, the others Q32
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			prod[i] = 105'(ll_s11[i]) + 105'({mid_s11[i], 32'b0}) + {hh_s11[i], 64'b0};
			val[i]  = (side_s11.mode == MODE_D1) ? prod[i][104:24] : 81'(prod[i][104:32]);
		end
	end

	// entries per request; a is lane 0, b is lane 1
	always_comb begin
		a48 = {1'b0, mag_s12[0]};
		b48 = {1'b0, mag_s12[1]};
		case (side_s12.mode)
			MODE_PROB: begin
				v[0] = 48'(Q32) - b48;
				v[1] = b48;
				v[2] = a48;
				v[3] = 48'(Q32) - a48;
			end
			MODE_D1: begin
				v[0] = 48'd0 - a48;
				v[1] = a48;
				v[2] = b48;
				v[3] = 48'd0 - b48;
			end
			MODE_D2: begin
				v[0] = a48;
				v[1] = 48'd0 - a48;
				v[2] = 48'd0 - b48;
				v[3] = b48;
			end
			default: begin
				for (int i = 0; i < 4; i++) v[i] = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		// s8: rate or rate^2 times e, in two halves
		if (en[0]) begin
			ph_s8   <= 48'(r_in[47:32]) * 48'(e_in[31:0]);
			pl_s8   <= 64'(r_in[31:0]) * 64'(e_in[31:0]);
			eh_s8   <= e_in[32];
			om_s8   <= Q32 - e_in;
			side_s8 <= side_in;
		end
		// s9: common factor
		if (en[1]) begin
			g_s9    <= g;
			side_s9 <= side_s8;
		end
		// s10: partial products per lane
		if (en[2]) begin
			for (int i = 0; i < 2; i++) begin
				ll_s10[i] <= 64'(coef[i][31:0]) * 64'(g_s9[31:0]);
				lh_s10[i] <= 49'(coef[i][31:0]) * 49'(g_s9[48:32]);
				hl_s10[i] <= 56'(coef[i][55:32]) * 56'(g_s9[31:0]);
				hh_s10[i] <= 41'(coef[i][55:32]) * 41'(g_s9[48:32]);
			end
			side_s10 <= side_s9;
		end
		// s11: middle terms
		if (en[3]) begin
			for (int i = 0; i < 2; i++) begin
				ll_s11[i]  <= ll_s10[i];
				mid_s11[i] <= 57'(lh_s10[i]) + 57'(hl_s10[i]);
				hh_s11[i]  <= hh_s10[i];
			end
			side_s11 <= side_s10;
		end
		// s12: magnitude with saturation
		if (en[4]) begin
			for (int i = 0; i < 2; i++) begin
				sat_s12[i] <= |val[i][80:47];
				mag_s12[i] <= (|val[i][80:47]) ? MAG_MAX : val[i][46:0];
			end
			side_s12 <= side_s11;
		end
		// s13: output register
		if (en[5]) begin
			for (int i = 0; i < 4; i++) v_s13[i] <= v[i];
			sel_s13 <= v[{side_s12.row, side_s12.col}];
			ov_s13  <= ((side_s12.mode == MODE_D1) || (side_s12.mode == MODE_D2))
			           && (sat_s12[0] || sat_s12[1]);
		end
	end

	assign entry_00       = v_s13[0];
	assign entry_01       = v_s13[1];
	assign entry_10       = v_s13[2];
	assign entry_11       = v_s13[3];
	assign selected_entry = sel_s13;
	assign overflow       = ov_s13;

endmodule
`default_nettype wire

// File: rtl/core/binary_model_transition_matrix_unit.sv
// Top level of the two-state transition matrix unit: handshake and stage valid chain.
`default_nettype none
// Accepts one branch length per clock while in_stall is low and returns P(d),
// dP/dd or d2P/dd2 of the two-state model, one result per item, in order. The
// stages advance independently, so bubbles close up behind a stalled output and
// the input keeps taking transfers until every stage holds an item. After any
// write to kappa or rate, a setup sequencer recomputes the derived constants
// (three 65-step divisions and four 5-step multiplications) and the input is
// stalled while it runs; after reset the constants for the reset register values
// are ready at once.
module binary_model_transition_matrix_unit import bmtm_pkg::*; #(
	parameter int EXP_TABLE_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [23:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [31:0] branch_length,
	input  logic        row_index,
	input  logic        col_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [47:0] entry_00,
	output logic [47:0] entry_01,
	output logic [47:0] entry_10,
	output logic [47:0] entry_11,
	output logic [47:0] selected_entry,
	output logic        overflow
);

	localparam int NS = 13;

	logic [NS-1:0] v_q;
	logic [NS-1:0] en;
	logic          busy;
	logic          in_acc;
	cfg_t          cfg;
	side_t         side_in, side_e;
	logic [32:0]   e;

	// a stage loads when it is empty or its content moves on
	always_comb begin
		en[NS-1] = ~v_q[NS-1] | ~out_stall;
		for (int i = NS-2; i >= 0; i--) en[i] = ~v_q[i] | en[i+1];
	end

	assign in_stall  = ~en[0] | busy;
	assign in_acc    = in_valid & ~in_stall;
	assign out_valid = v_q[NS-1];
	assign side_in   = '{mode: req_type, row: row_index, col: col_index};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) v_q[0] <= in_acc;
			for (int i = 1; i < NS; i++) begin
				if (en[i]) v_q[i] <= v_q[i-1];
			end
		end
	end

	bmtm_setup u_setup (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.busy      (busy),
		.cfg       (cfg)
	);

	bmtm_exp #(
		.EXP_TABLE_BITS (EXP_TABLE_BITS)
	) u_exp (
		.clk           (clk),
		.en            (en[6:0]),
		.dr            (cfg.dr),
		.branch_length (branch_length),
		.side_in       (side_in),
		.e_out         (e),
		.side_out      (side_e)
	);

	bmtm_mat u_mat (
		.clk            (clk),
		.en             (en[12:7]),
		.cfg            (cfg),
		.e_in           (e),
		.side_in        (side_e),
		.entry_00       (entry_00),
		.entry_01       (entry_01),
		.entry_10       (entry_10),
		.entry_11       (entry_11),
		.selected_entry (selected_entry),
		.overflow       (overflow)
	);

endmodule
`default_nettype wire

// File: verif/bmtm_checker.sv
// Checker for the transition matrix unit: watches both channels, predicts and compares results.
module bmtm_checker import bmtm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [23:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [31:0] branch_length,
	input  logic        row_index,
	input  logic        col_index,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [47:0] entry_00,
	input  logic [47:0] entry_01,
	input  logic [47:0] entry_10,
	input  logic [47:0] entry_11,
	input  logic [47:0] selected_entry,
	input  logic        overflow,
	output int          errors,
	output int          pending
);

	localparam int TBITS = 8;
	localparam logic [63:0] ONE = 64'h1_0000_0000;

	typedef struct packed {
		logic [47:0] e00;
		logic [47:0] e01;
		logic [47:0] e10;
		logic [47:0] e11;
		logic [47:0] sel;
		logic        ov;
	} matrix_t;

	matrix_t     matrix_q[$];
	logic [63:0] kappa_r, rate_r, lambda_r, inv_k1_r, half_k1_r, half_k1_over_k_r;
	logic [63:0] pow2_tab[1 << TBITS];

	// floor(a*b / 2^sh) over the full product, clamped to cap
	function automatic logic [63:0] mul_trunc(input logic [63:0] a, input logic [63:0] b,
			input int sh, input logic [63:0] cap, inout bit ov);
		logic [127:0] p;
		p = ({64'd0, a} * {64'd0, b}) >> sh;
		if (p > {64'd0, cap}) begin
			ov = 1'b1;
			return cap;
		end
		return p[63:0];
	endfunction

	// exp(-u) by a truncated Horner series, Q1.32
	function automatic logic [63:0] exp_horner(input logic [63:0] u);
		logic [63:0] acc;
		acc = ONE;
		for (int n = EXP_TERMS; n >= 1; n--)
			acc = ONE - (((u * acc) >> 32) / n);
		return acc;
	endfunction

	// reciprocals and lambda from kappa
	task automatic rederive();
		logic [63:0] k1, sq, q, r;
		k1 = kappa_r + 64'd65536;
		half_k1_r = k1 << 7;
		if (kappa_r == 0) begin
			inv_k1_r = 64'hFFFF_FFFF;
			half_k1_over_k_r = (64'd1 << 40) - 1;
			lambda_r = (64'd1 << 40) - 1;
		end else begin
			inv_k1_r = (64'd1 << 48) / k1;
			half_k1_over_k_r = (k1 << 23) / kappa_r;
			sq = k1 * k1;
			q = sq / kappa_r;
			r = sq % kappa_r;
			lambda_r = (q >= (64'd1 << 25)) ? (64'd1 << 40) - 1
				: (q << 15) + ((r << 15) / kappa_r);
		end
	endtask

	// e = exp(-lambda*rate*d), Q1.32
	function automatic logic [63:0] decay(input logic [31:0] d);
		bit ign;
		logic [63:0] x, y, f, idx, rem, r, q, t, m, n;
		ign = 0;
		x = mul_trunc(lambda_r * rate_r, {32'd0, d}, 40, 64'd1 << 37, ign);
		if (x >= (64'd1 << 37)) return 64'd0;
		y = mul_trunc(x, {31'd0, LOG2E_Q32}, 32, '1, ign);
		n = y >> 32;
		if (n > 32) return 64'd0;
		f = y & 64'hFFFF_FFFF;
		idx = f >> (32 - TBITS);
		rem = f & ((ONE >> TBITS) - 1);
		r = (rem * {32'd0, LN2_Q32}) >> 32;
		q = r - ((r * r) >> 33);
		t = pow2_tab[idx[TBITS-1:0]];
		m = t - ((t * q) >> 32);
		return m >> n;
	endfunction

	function automatic matrix_t predict_matrix(input logic [1:0] mode, input logic [31:0] d,
			input logic row, input logic col);
		matrix_t res;
		bit ov, ign;
		logic [63:0] e, om, p01, p10, g, a, b, ca, cb;
		logic [63:0] v[4];
		ov = 0;
		ign = 0;
		e = decay(d);
		v = '{default: 64'd0};
		case (mode)
			MODE_PROB: begin
				om = ONE - e;
				p10 = (inv_k1_r * om) >> 32;
				p01 = ((ONE - inv_k1_r) * om) >> 32;
				v = '{ONE - p01, p01, p10, ONE - p10};
			end
			MODE_D1: begin
				g = mul_trunc(rate_r, e, 16, '1, ign);
				a = mul_trunc(half_k1_r, g, 24, {17'd0, MAG_MAX}, ov);
				b = mul_trunc(half_k1_over_k_r, g, 24, {17'd0, MAG_MAX}, ov);
				v = '{-a, a, b, -b};
			end
			MODE_D2: begin
				g = mul_trunc(rate_r * rate_r, e, 32, '1, ign);
				ca = mul_trunc(lambda_r, half_k1_r, 24, '1, ign);
				cb = mul_trunc(lambda_r, half_k1_over_k_r, 24, '1, ign);
				a = mul_trunc(ca, g, 32, {17'd0, MAG_MAX}, ov);
				b = mul_trunc(cb, g, 32, {17'd0, MAG_MAX}, ov);
				v = '{a, -a, -b, b};
			end
			default: ;
		endcase
		res.e00 = v[0][47:0];
		res.e01 = v[1][47:0];
		res.e10 = v[2][47:0];
		res.e11 = v[3][47:0];
		res.sel = v[{row, col}][47:0];
		res.ov = ov;
		return res;
	endfunction

	initial begin
		for (int k = 0; k < (1 << TBITS); k++)
			pow2_tab[k] = exp_horner((64'(k) * {32'd0, LN2_Q32}) >> TBITS);
	end

	assign pending = matrix_q.size();

	// track config, predict on input transfers, compare on output transfers
	always @(posedge clk or negedge arst_n) begin
		matrix_t exp_m, got;
		if (!arst_n) begin
			kappa_r = 64'd65536;
			rate_r = 64'd65536;
			rederive();
			matrix_q.delete();
			errors = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_KAPPA) begin
					kappa_r = {40'd0, cfg_data};
					rederive();
				end else begin
					rate_r = {40'd0, cfg_data};
				end
			end
			if (in_valid && !in_stall)
				matrix_q.push_back(predict_matrix(req_type, branch_length, row_index, col_index));
			if (out_valid && !out_stall) begin
				got = '{entry_00, entry_01, entry_10, entry_11, selected_entry, overflow};
				if (matrix_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("ERROR: result transfer with nothing expected: %h", got);
				end else begin
					exp_m = matrix_q.pop_front();
					if (got !== exp_m) begin
						errors++;
						if (errors <= 10)
							$display("ERROR: entries mismatch\n  expected %h %h %h %h sel %h ov %b\n  actual   %h %h %h %h sel %h ov %b",
								exp_m.e00, exp_m.e01, exp_m.e10, exp_m.e11, exp_m.sel, exp_m.ov,
								got.e00, got.e01, got.e10, got.e11, got.sel, got.ov);
					end
				end
			end
		end
	end

endmodule

// File: verif/tb_binary_model_transition_matrix_unit.sv
// Testbench top of the transition matrix unit: clock, reset, stimulus and verdict.
module tb_binary_model_transition_matrix_unit;
	import bmtm_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [23:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  req_type = '0;
	logic [31:0] branch_length = '0;
	logic        row_index = 1'b0;
	logic        col_index = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [47:0] entry_00, entry_01, entry_10, entry_11, selected_entry;
	logic        overflow;
	int          errors, pending;
	bit          calm = 1'b0;

	always #5 clk = ~clk;

	binary_model_transition_matrix_unit i_dut (.*);

	bmtm_checker i_checker (.*);

	// random backpressure on the result side
	always @(posedge clk)
		out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 29);

	// one input transfer, with random idle cycles ahead of it
	task automatic send_branch(input logic [1:0] mode, input logic [31:0] d,
			input logic row, input logic col);
		int gap;
		bit done;
		gap = 0;
		while (!calm && $urandom_range(0, 99) < 29) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= mode;
		branch_length <= d;
		row_index <= row;
		col_index <= col;
		do begin
			@(negedge clk);
			done = !in_stall;
			@(posedge clk);
		end while (!done);
	endtask

	// register write once every result is back and the pipe has emptied
	task automatic write_reg(input logic idx, input logic [23:0] val);
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly short branches so the exponential is not flushed to zero
	function automatic logic [31:0] rand_branch();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return $urandom_range(0, 255);
			default: return $urandom() >> $urandom_range(4, 31);
		endcase
	endfunction

	task automatic run_phase(input int n);
		logic [31:0] corners[4] = '{32'd0, 32'hFFFF_FFFF, 32'h0100_0000, 32'd1};
		for (int m = 0; m < 4; m++)
			for (int c = 0; c < 4; c++)
				send_branch(m[1:0], corners[c], c[1], c[0]);
		for (int i = 0; i < n; i++) begin
			calm = (i >= n / 3 && i < n / 3 + 60);
			send_branch($urandom_range(0, 99) < 5 ? 2'd3 : 2'($urandom_range(0, 2)),
				rand_branch(), 1'($urandom), 1'($urandom));
		end
		calm = 1'b0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_phase(250);
		write_reg(REG_KAPPA, 24'd1);
		run_phase(220);
		write_reg(REG_KAPPA, 24'hFF_FFFF);
		write_reg(REG_RATE, 24'd0);
		run_phase(220);
		write_reg(REG_RATE, 24'hFF_FFFF);
		run_phase(220);
		write_reg(REG_KAPPA, 24'd0);
		run_phase(220);
		write_reg(REG_KAPPA, 24'd1);
		run_phase(220);
		write_reg(REG_KAPPA, 24'h03_2000);
		write_reg(REG_RATE, 24'h00_4000);
		run_phase(220);
		write_reg(REG_KAPPA, 24'($urandom_range(1, 24'hFF_FFFF)));
		write_reg(REG_RATE, 24'($urandom_range(0, 24'h0F_FFFF)));
		run_phase(220);
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// watchdog
	initial begin
		#20000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
